FILE: rtl/oirp_pkg.sv
package oirp_pkg;

	// Command bytes and markers
	localparam logic [7:0] CMD_RESTART   = 8'hc9;
	localparam logic [7:0] MARK_RESTART  = 8'hd5;
	localparam logic [7:0] CMD_FINISH    = 8'h6b;
	localparam logic [7:0] CMD_ABORT     = 8'h00;
	localparam logic [7:0] MARK_ABORT    = 8'hff;
	localparam logic [7:0] CMD_DATA      = 8'h38;
	localparam logic [7:0] CMD_DATA_MASK = 8'hfe;

	// Packet lengths that select the short commands, and the header length
	localparam logic [7:0] LEN_SHORT_CMD = 8'd2;
	localparam logic [7:0] LEN_FINISH    = 8'd4;
	localparam logic [7:0] LEN_HEADER    = 8'd4;

	// Upper nibble of the reply status
	localparam logic [3:0] ST_OK        = 4'h0;
	localparam logic [3:0] ST_MISSED    = 4'h4;
	localparam logic [3:0] ST_DUPLICATE = 4'h8;
	localparam logic [3:0] ST_COMMIT    = 4'hf;

	// Reply lengths
	localparam logic [2:0] REPLY_NONE  = 3'd0;
	localparam logic [2:0] REPLY_SHORT = 3'd1;
	localparam logic [2:0] REPLY_LONG  = 3'd4;

	localparam int OFS_W   = 24;
	localparam int PAGE_W  = 10;
	localparam int COPY_W  = 11;
	// Divider by reciprocal: 25-bit dividend, 26-bit multiplier
	localparam int DIVX_W  = 25;
	localparam int DIVM_W  = 26;
	localparam int PROD_W  = DIVX_W + DIVM_W;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		KIND_UNKNOWN,
		KIND_RESTART,
		KIND_FINISH,
		KIND_ABORT,
		KIND_DATA
	} pkt_kind_t;

	typedef struct packed {
		pkt_kind_t          kind;
		logic               reply4;
		logic [OFS_W-1:0]   offset;
		logic [7:0]         plen;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Decision made at execute, before the page arithmetic
	typedef struct packed {
		logic [2:0]         reply_length;
		logic               stat_en;
		logic [3:0]         stat_nib;
		logic [OFS_W-1:0]   reply_offset;
		logic               payload_write;
		logic [OFS_W-1:0]   payload_addr;
		logic [7:0]         payload_bytes;
		logic               program_page;
		logic               abort_flag;
		logic               commit_flag;
	} exec_t;

	typedef struct packed {
		logic [2:0]         reply_length;
		logic [7:0]         reply_status;
		logic [OFS_W-1:0]   reply_offset;
		logic               payload_write;
		logic [OFS_W-1:0]   payload_addr;
		logic [7:0]         payload_bytes;
		logic               program_page;
		logic [PAGE_W-1:0]  page_number;
		logic               abort_flag;
		logic               commit_flag;
		logic [COPY_W-1:0]  copy_pages;
	} result_t;

endpackage

FILE: rtl/ota_image_receive_protocol.sv
// OTA image receiver: decodes the header of each received update packet.
//
// Input channel (in_valid / in_stall): one item per packet, its length and
// first four bytes. An item is taken on a clock edge with in_valid high and
// in_stall low. in_stall rises only when the four-entry item queue is full.
// Output channel (out_valid / out_stall): exactly one result per item, in
// order. A stalled result holds on the ports; the front keeps taking items
// into the queue meanwhile.
// Config channel (cfg_valid / cfg_ready / node_id): ready is always high;
// the id lands in the low nibble of the reply status of every restart,
// finish and data result. Write it only while no item is in flight.
// A result passes the queue, execute, reciprocal multiply and output
// register before out_valid rises. Throughput: one item per cycle while
// no stalled result holds the output; the running length and page start
// update in execute as the item leaves the queue, and the page and
// copy-count divisions run as a two-stage multiply by a constant reciprocal.
// Reset (arst_n low): queue and pipeline empty, running length, page start
// and node id all zero.
module ota_image_receive_protocol #(
	parameter int PAGE_BYTES  = 256,
	parameter int FLASH_PAGES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  pkt_len,
	input  logic [7:0]  byte0,
	input  logic [7:0]  byte1,
	input  logic [7:0]  byte2,
	input  logic [7:0]  byte3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  reply_length,
	output logic [7:0]  reply_status,
	output logic [23:0] reply_offset,
	output logic        payload_write,
	output logic [23:0] payload_addr,
	output logic [7:0]  payload_bytes,
	output logic        program_page,
	output logic [9:0]  page_number,
	output logic        abort_flag,
	output logic        commit_flag,
	output logic [10:0] copy_pages,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  node_id
);

	oirp_pkg::q_stat_t q_stat;
	oirp_pkg::item_t   wr_item;
	oirp_pkg::item_t   rd_item;
	oirp_pkg::result_t res;
	logic              push;
	logic              pop;

	// config register is always writable
	assign cfg_ready = 1'b1;

	// front: classify and enqueue
	oirp_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.pkt_len  (pkt_len),
		.byte0    (byte0),
		.byte1    (byte1),
		.byte2    (byte2),
		.byte3    (byte3),
		.q_stat   (q_stat),
		.push     (push),
		.item     (wr_item)
	);

	// decouples front from back
	oirp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.stat    (q_stat)
	);

	// back: protocol state, page tracking, result register
	oirp_back #(
		.PAGE_BYTES  (PAGE_BYTES),
		.FLASH_PAGES (FLASH_PAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.node_id   (node_id),
		.q_stat    (q_stat),
		.item      (rd_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (res)
	);

	assign reply_length  = res.reply_length;
	assign reply_status  = res.reply_status;
	assign reply_offset  = res.reply_offset;
	assign payload_write = res.payload_write;
	assign payload_addr  = res.payload_addr;
	assign payload_bytes = res.payload_bytes;
	assign program_page  = res.program_page;
	assign page_number   = res.page_number;
	assign abort_flag    = res.abort_flag;
	assign commit_flag   = res.commit_flag;
	assign copy_pages    = res.copy_pages;

endmodule

FILE: rtl/oirp_front.sv
module oirp_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        pkt_len,
	input  logic [7:0]        byte0,
	input  logic [7:0]        byte1,
	input  logic [7:0]        byte2,
	input  logic [7:0]        byte3,
	input  oirp_pkg::q_stat_t q_stat,
	output logic              push,
	output oirp_pkg::item_t   item
);

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		item        = '0;
		item.offset = {byte3, byte2, byte1};
		item.plen   = pkt_len - oirp_pkg::LEN_HEADER;
		item.reply4 = byte0[0];
		if (pkt_len == oirp_pkg::LEN_SHORT_CMD && byte0 == oirp_pkg::CMD_RESTART &&
				byte1 == oirp_pkg::MARK_RESTART) begin
			item.kind = oirp_pkg::KIND_RESTART;
		end else if (pkt_len == oirp_pkg::LEN_FINISH && byte0 == oirp_pkg::CMD_FINISH) begin
			item.kind = oirp_pkg::KIND_FINISH;
		end else if (pkt_len == oirp_pkg::LEN_SHORT_CMD && byte0 == oirp_pkg::CMD_ABORT &&
				byte1 == oirp_pkg::MARK_ABORT) begin
			item.kind = oirp_pkg::KIND_ABORT;
		end else if (pkt_len != 8'd0 && pkt_len[1:0] == 2'b00 &&
				(byte0 & oirp_pkg::CMD_DATA_MASK) == oirp_pkg::CMD_DATA) begin
			item.kind = oirp_pkg::KIND_DATA;
		end else begin
			item.kind = oirp_pkg::KIND_UNKNOWN;
		end
	end

endmodule

FILE: rtl/oirp_queue.sv
module oirp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  oirp_pkg::item_t   wr_item,
	input  logic              pop,
	output oirp_pkg::item_t   rd_item,
	output oirp_pkg::q_stat_t stat
);

	localparam int PTR_W = $clog2(oirp_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(oirp_pkg::QUEUE_DEPTH + 1);

	oirp_pkg::item_t  mem_q [oirp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(oirp_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/oirp_back.sv
module oirp_back #(
	parameter int PAGE_BYTES  = 256,
	parameter int FLASH_PAGES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [3:0]        node_id,
	input  oirp_pkg::q_stat_t q_stat,
	input  oirp_pkg::item_t   item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output oirp_pkg::result_t result
);

	localparam int OFS_W  = oirp_pkg::OFS_W;
	localparam int DIV_SH = oirp_pkg::DIVX_W + $clog2(PAGE_BYTES);
	// ceil(2^DIV_SH / PAGE_BYTES): exact floor division for 25-bit dividends
	localparam logic [63:0] DIV_MUL_64 =
		((64'd1 << DIV_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
	localparam logic [oirp_pkg::DIVM_W-1:0] DIV_MUL = DIV_MUL_64[oirp_pkg::DIVM_W-1:0];
	localparam logic [oirp_pkg::PAGE_W-1:0] PAGE_BASE = oirp_pkg::PAGE_W'(FLASH_PAGES / 2);

	logic [3:0]       node_id_q;
	logic [OFS_W-1:0] rcv_len_q;
	logic [OFS_W-1:0] page_begin_q;

	logic adv;

	// execute
	oirp_pkg::exec_t  ex;
	logic [OFS_W-1:0] nxt_len;
	logic [OFS_W-1:0] nxt_begin;
	logic [OFS_W-1:0] div_x;
	logic [OFS_W-1:0] data_end;
	logic [OFS_W-1:0] fill;
	logic             ofs_gt;
	logic             ofs_lt;

	logic                              v_s1;
	oirp_pkg::exec_t                   ex_s1;
	logic [oirp_pkg::DIVX_W-1:0]       xf_s1;
	logic [oirp_pkg::DIVX_W-1:0]       xc_s1;

	logic                              v_s2;
	oirp_pkg::exec_t                   ex_s2;
	logic [oirp_pkg::PROD_W-1:0]       pf_s2;
	logic [oirp_pkg::PROD_W-1:0]       pc_s2;

	logic              out_valid_q;
	oirp_pkg::result_t result_q;
	oirp_pkg::result_t res_d;

	assign adv       = !out_valid_q || !out_stall;
	assign pop       = adv && !q_stat.empty;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	assign ofs_gt   = item.offset > rcv_len_q;
	assign ofs_lt   = item.offset < rcv_len_q;
	assign data_end = rcv_len_q + OFS_W'(item.plen);
	assign fill     = data_end - page_begin_q;

	always_comb begin
		ex              = '0;
		ex.reply_offset = rcv_len_q;
		nxt_len         = rcv_len_q;
		nxt_begin       = page_begin_q;
		div_x           = '0;
		case (item.kind)
			oirp_pkg::KIND_RESTART: begin
				ex.reply_length = oirp_pkg::REPLY_SHORT;
				ex.stat_en      = 1'b1;
				ex.stat_nib     = oirp_pkg::ST_OK;
				nxt_len         = '0;
				nxt_begin       = '0;
			end
			oirp_pkg::KIND_FINISH: begin
				ex.reply_length = oirp_pkg::REPLY_LONG;
				ex.stat_en      = 1'b1;
				if (ofs_gt) begin
					ex.stat_nib = oirp_pkg::ST_MISSED;
				end else if (ofs_lt) begin
					ex.stat_nib = oirp_pkg::ST_DUPLICATE;
				end else begin
					// last partial page, if any, then commit
					ex.stat_nib     = oirp_pkg::ST_COMMIT;
					ex.commit_flag  = 1'b1;
					ex.program_page = (rcv_len_q != page_begin_q);
					div_x           = rcv_len_q;
				end
			end
			oirp_pkg::KIND_ABORT: begin
				ex.abort_flag = 1'b1;
			end
			oirp_pkg::KIND_DATA: begin
				ex.reply_length = item.reply4 ? oirp_pkg::REPLY_LONG : oirp_pkg::REPLY_NONE;
				ex.stat_en      = 1'b1;
				if (ofs_gt) begin
					ex.stat_nib = oirp_pkg::ST_MISSED;
				end else if (ofs_lt) begin
					ex.stat_nib = oirp_pkg::ST_DUPLICATE;
				end else begin
					ex.stat_nib      = oirp_pkg::ST_OK;
					ex.payload_write = 1'b1;
					ex.payload_addr  = rcv_len_q;
					ex.payload_bytes = item.plen;
					nxt_len          = data_end;
					// at most one page request per packet
					if (fill >= OFS_W'(PAGE_BYTES)) begin
						ex.program_page = 1'b1;
						div_x           = page_begin_q;
						nxt_begin       = data_end;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_d               = '0;
		res_d.reply_length  = ex_s2.reply_length;
		res_d.reply_status  = ex_s2.stat_en ? {ex_s2.stat_nib, node_id_q} : 8'h00;
		res_d.reply_offset  = ex_s2.reply_offset;
		res_d.payload_write = ex_s2.payload_write;
		res_d.payload_addr  = ex_s2.payload_addr;
		res_d.payload_bytes = ex_s2.payload_bytes;
		res_d.program_page  = ex_s2.program_page;
		res_d.page_number   = ex_s2.program_page ?
			pf_s2[DIV_SH +: oirp_pkg::PAGE_W] + PAGE_BASE : '0;
		res_d.abort_flag    = ex_s2.abort_flag;
		res_d.commit_flag   = ex_s2.commit_flag;
		res_d.copy_pages    = ex_s2.commit_flag ? pc_s2[DIV_SH +: oirp_pkg::COPY_W] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q    <= '0;
			rcv_len_q    <= '0;
			page_begin_q <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				node_id_q <= node_id;
			end
			if (pop) begin
				rcv_len_q    <= nxt_len;
				page_begin_q <= nxt_begin;
			end
			if (adv) begin
				v_s1        <= pop;
				v_s2        <= v_s1;
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s1    <= ex;
			xf_s1    <= oirp_pkg::DIVX_W'(div_x);
			xc_s1    <= oirp_pkg::DIVX_W'(div_x) + oirp_pkg::DIVX_W'(PAGE_BYTES - 1);
			ex_s2    <= ex_s1;
			pf_s2    <= oirp_pkg::PROD_W'(xf_s1) * oirp_pkg::PROD_W'(DIV_MUL);
			pc_s2    <= oirp_pkg::PROD_W'(xc_s1) * oirp_pkg::PROD_W'(DIV_MUL);
			result_q <= res_d;
		end
	end

endmodule

FILE: rtl/oirp_checker.sv
module oirp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  reply_length,
	input logic [7:0]  reply_status,
	input logic [23:0] reply_offset,
	input logic        payload_write,
	input logic [7:0]  payload_bytes,
	input logic        abort_flag,
	input logic        commit_flag
);

	// stalled result holds its status, offset and length
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reply_status) &&
			$stable(reply_offset) && $stable(reply_length))
		else $error("stalled result changed");

	// commit always answers with a long reply and commit status
	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && commit_flag |->
			reply_length == 3'd4 && reply_status[7:4] == 4'hf && !payload_write)
		else $error("bad commit result");

	// accepted data: ok status, whole words of payload
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_write |->
			reply_status[7:4] == 4'h0 && payload_bytes[1:0] == 2'b00 && !abort_flag)
		else $error("bad data result");

	// abort carries no reply
	a_abort: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && abort_flag |-> reply_status == 8'h00 && reply_length == 3'd0)
		else $error("abort with reply");

endmodule

bind ota_image_receive_protocol oirp_checker u_oirp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.reply_length  (reply_length),
	.reply_status  (reply_status),
	.reply_offset  (reply_offset),
	.payload_write (payload_write),
	.payload_bytes (payload_bytes),
	.abort_flag    (abort_flag),
	.commit_flag   (commit_flag)
);
